// File: src/ucbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbs_pkg
// Shared types, codes and constants of the uniform cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package ucbs_pkg;

    // fixed point fraction bits of positions, control points and results
    localparam int FRAC_BITS          = 16;
    localparam int CTRL_DEPTH_DEFAULT = 256;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // evaluation modes, the unused code evaluates the value
    localparam logic [1:0] MODE_VALUE  = 2'd0;
    localparam logic [1:0] MODE_DERIV1 = 2'd1;
    localparam logic [1:0] MODE_DERIV2 = 2'd2;

    // register indexes
    localparam logic [1:0] REG_X_MIN   = 2'd0;
    localparam logic [1:0] REG_INV_DX  = 2'd1;
    localparam logic [1:0] REG_NUM_SEG = 2'd2;

    localparam logic [31:0] X_MIN_RESET   = 32'd0;
    localparam logic [31:0] INV_DX_RESET  = 32'(64'd1 << FRAC_BITS);
    localparam logic [7:0]  NUM_SEG_RESET = 8'd1;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         point_index;
        logic signed [31:0] point_value;
        logic signed [31:0] x_pos;
        logic [1:0]         eval_mode;
    } item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               out_of_range;
        logic               saturated;
    } result_t;

    // control that travels down the pipeline with each evaluation
    typedef struct packed {
        logic [1:0] mode;
        logic       oor;
        logic       neg;
    } ctl_t;

endpackage

// File: src/ucbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucbs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ucbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/uniform_cubic_bspline_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_eval_top
// One-dimensional uniform cubic B-spline evaluator, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// usage
//   items are issued with start; one is taken at every clock edge with start
//   high and busy low, and busy is never raised, so one item per cycle
//   a write item (cmd write) stores point_value at point_index and gives no
//   result; an evaluate item gives exactly one result on the result port,
//   marked by done for a single cycle
//   results leave in issue order; the receiver cannot stall, so there is no
//   back pressure anywhere and the pipeline never holds
//   throughput is one item per clock; the pipeline has 17 stages, among
//   them three stages of 32x32 multipliers, the tap multipliers and a
//   two-step divide by 3
//   control points live in four RAM banks chosen by index modulo four, so
//   the four taps of a segment are read in the same cycle
//   configuration goes through the APB-style port while the block is idle;
//   x_min at 0x0, inv_dx at 0x4, num_segments at 0x8
//   reset clears the pipeline valid bits and loads x_min 0, inv_dx 1.0 and
//   one segment; control points are undefined until written
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_eval_top #(
    parameter int CTRL_DEPTH = ucbs_pkg::CTRL_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ucbs_pkg::item_t   item,
    output logic              done,
    output ucbs_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ucbs_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int LAT  = 17;              // accept edge to result edge
    localparam int NW   = F + 4;           // basis weight width, signed
    localparam int WE   = NW + 2;          // weight working width
    localparam int PW   = 32 + NW;         // tap product width
    localparam int SW   = PW + 2;          // tap sum width
    localparam int TW   = SW + 1 - F;      // rounded quotient width
    localparam int QW   = TW;
    localparam int AW   = 33;              // capped dividend for the divide by 3
    localparam int M1W  = 32 + F;          // capped magnitude after first scaling
    localparam int TQW  = 64 - F;
    localparam int IW   = $clog2(CTRL_DEPTH);
    localparam int RW   = IW - 2;
    localparam int AEW  = (IW > 9) ? IW : 9;
    localparam int BANK_DEPTH = CTRL_DEPTH / 4;

    localparam logic [2*F-1:0] HALF_SQ = (2*F)'(64'd1 << (F - 1));
    localparam logic [SW:0]    RND_VAL = (SW+1)'(64'd3 << F);
    localparam logic [SW:0]    RND_D1  = (SW+1)'(64'd1 << F);
    localparam logic [SW:0]    RND_D2  = (SW+1)'(64'd1 << (F - 1));
    localparam logic [QW+31:0]  RND_M1 = (QW+32)'(64'd1 << (F - 1));
    localparam logic [M1W+31:0] RND_M2 = (M1W+32)'(64'd1 << (F - 1));

    localparam logic signed [WE-1:0] KS = WE'(64'd1 << F);
    localparam logic signed [WE-1:0] K2 = WE'(2);
    localparam logic signed [WE-1:0] K3 = WE'(3);
    localparam logic signed [WE-1:0] K4 = WE'(4);
    localparam logic signed [WE-1:0] K6 = WE'(6);

    // reciprocal multipliers for exact division by 3
    localparam logic [17:0] M17 = 18'(((64'd1 << 18) + 64'd2) / 64'd3);
    localparam logic [18:0] M18 = 19'(((64'd1 << 19) + 64'd2) / 64'd3);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [31:0] x_min_reg;
    logic [31:0] inv_dx_reg;
    logic [7:0]  num_seg_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg   <= X_MIN_RESET;
            inv_dx_reg  <= INV_DX_RESET;
            num_seg_reg <= NUM_SEG_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_X_MIN:   x_min_reg   <= pwdata;
                REG_INV_DX:  inv_dx_reg  <= pwdata;
                REG_NUM_SEG: num_seg_reg <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_MIN:   prdata = x_min_reg;
            REG_INV_DX:  prdata = inv_dx_reg;
            REG_NUM_SEG: prdata = {24'd0, num_seg_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------------
    // valid bits, write items drop out after the RAM stage
    // ------------------------------------------------------------------------
    logic [LAT:1] vld_reg;
    logic         accept;
    logic         cmd1_reg, cmd2_reg, cmd3_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg[1]     <= accept;
            vld_reg[2]     <= vld_reg[1];
            vld_reg[3]     <= vld_reg[2];
            vld_reg[4]     <= vld_reg[3] && (cmd3_reg == CMD_EVAL);
            vld_reg[LAT:5] <= vld_reg[LAT-1:4];
        end
    end

    // ------------------------------------------------------------------------
    // stages 1 to 3: offset, scale to spline parameter, clamp and split
    // ------------------------------------------------------------------------
    logic [7:0]        idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]       val1_reg, val2_reg, val3_reg;
    logic [1:0]        md1_reg, md2_reg;
    logic [32:0]       diff1_reg;
    logic [63:0]       prod2_reg;
    logic              neg2_reg;
    logic [7:0]        seg3_reg;
    logic [F-1:0]      frac3_reg;
    ctl_t              ctl_reg [LAT-1:3];

    logic [32:0]       diff_next;
    logic [TQW-1:0]    tq, limit, tqc;
    logic              over;
    ctl_t              ctl3_next;

    assign diff_next = {item.x_pos[31], item.x_pos} - {x_min_reg[31], x_min_reg};

    always_comb
    begin
        tq    = neg2_reg ? '0 : prod2_reg[63:F];
        limit = TQW'({num_seg_reg, {F{1'b0}}});
        over  = tq > limit;
        tqc   = over ? limit : tq;
        ctl3_next.mode = md2_reg;
        ctl3_next.oor  = (neg2_reg && (inv_dx_reg != 32'd0)) || over;
        ctl3_next.neg  = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg  <= item.cmd;
        idx1_reg  <= item.point_index;
        val1_reg  <= item.point_value;
        md1_reg   <= item.eval_mode;
        diff1_reg <= diff_next;

        cmd2_reg  <= cmd1_reg;
        idx2_reg  <= idx1_reg;
        val2_reg  <= val1_reg;
        md2_reg   <= md1_reg;
        neg2_reg  <= diff1_reg[32];
        prod2_reg <= {32'd0, diff1_reg[31:0]} * {32'd0, inv_dx_reg};

        cmd3_reg   <= cmd2_reg;
        idx3_reg   <= idx2_reg;
        val3_reg   <= val2_reg;
        seg3_reg   <= tqc[F+7:F];
        frac3_reg  <= tqc[F-1:0];
        ctl_reg[3] <= ctl3_next;
    end

    // ------------------------------------------------------------------------
    // control point banks, tap seg+j sits in bank (seg+j) mod 4
    // ------------------------------------------------------------------------
    logic [31:0]   rd_data [4];
    logic [RW-1:0] rd_addr [4];
    logic [AEW-1:0] widx;

    assign widx = AEW'(idx3_reg);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [1:0]     jb;
        logic [AEW-1:0] taddr;
        logic           bank_wr;

        assign jb      = 2'(b) - seg3_reg[1:0];
        assign taddr   = AEW'(seg3_reg) + AEW'(jb);
        assign bank_wr = vld_reg[3] && (cmd3_reg == CMD_WRITE) && (widx[1:0] == 2'(b));
        assign rd_addr[b] = taddr[IW-1:2];

        ucbs_ram #(
            .WIDTH (32),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_wr),
            .wr_addr (widx[IW-1:2]),
            .wr_data (val3_reg),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    // ------------------------------------------------------------------------
    // stages 4 to 6: powers of the fraction, tap routing, basis weights
    // ------------------------------------------------------------------------
    logic [1:0]        seglo4_reg;
    logic              skip4_reg;
    logic [F-1:0]      frac4_reg, frac5_reg;
    logic [F-1:0]      u2_4_reg, u2_5_reg, u3_5_reg;
    logic signed [31:0] taps5_reg [4];
    logic signed [31:0] taps6_reg [4];
    logic signed [NW-1:0] w6_reg [4];

    logic [2*F-1:0]    sq_next, cu_next;
    logic signed [31:0] taps_next [4];
    logic signed [WE-1:0] uu, p2, p3;
    logic signed [WE-1:0] w_next [4];

    assign sq_next = (2*F)'(frac3_reg) * (2*F)'(frac3_reg) + HALF_SQ;
    assign cu_next = (2*F)'(u2_4_reg) * (2*F)'(frac4_reg) + HALF_SQ;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            taps_next[j] = rd_data[2'(seglo4_reg + 2'(j))];
        end
        // end of domain: the last tap carries no weight
        if (skip4_reg)
        begin
            taps_next[3] = '0;
        end
    end

    always_comb
    begin
        uu = WE'(frac5_reg);
        p2 = WE'(u2_5_reg);
        p3 = WE'(u3_5_reg);
        case (ctl_reg[5].mode)
            MODE_DERIV1:
            begin
                w_next[3] = p2;
                w_next[2] = KS + K2 * uu - K3 * p2;
                w_next[1] = K3 * p2 - K4 * uu;
                w_next[0] = K2 * uu - p2 - KS;
            end
            MODE_DERIV2:
            begin
                w_next[3] = uu;
                w_next[2] = KS - K3 * uu;
                w_next[1] = K3 * uu - K2 * KS;
                w_next[0] = KS - uu;
            end
            default:
            begin
                w_next[3] = p3;
                w_next[2] = KS + K3 * uu + K3 * p2 - K3 * p3;
                w_next[1] = K4 * KS + K3 * p3 - K6 * p2;
                w_next[0] = KS - K3 * uu + K3 * p2 - p3;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        seglo4_reg <= seg3_reg[1:0];
        skip4_reg  <= seg3_reg == num_seg_reg;
        frac4_reg  <= frac3_reg;
        u2_4_reg   <= sq_next[2*F-1:F];
        ctl_reg[4] <= ctl_reg[3];

        frac5_reg  <= frac4_reg;
        u2_5_reg   <= u2_4_reg;
        u3_5_reg   <= cu_next[2*F-1:F];
        taps5_reg  <= taps_next;
        ctl_reg[5] <= ctl_reg[4];

        for (int j = 0; j < 4; j++)
        begin
            w6_reg[j] <= w_next[j][NW-1:0];
        end
        taps6_reg  <= taps5_reg;
        ctl_reg[6] <= ctl_reg[5];
    end

    // ------------------------------------------------------------------------
    // stages 7 to 12: tap products, sum, magnitude, rounding divide
    // ------------------------------------------------------------------------
    logic signed [PW-1:0] prod7_reg [4];
    logic signed [SW-1:0] sum8_reg;
    logic [SW-1:0]        mag9_reg;
    logic [AW-1:0]        a10_reg;
    logic [QW-1:0]        qd10_reg, qd11_reg, q12_reg;
    logic [16:0]          qh11_reg;
    logic [17:0]          x11_reg;

    logic [SW:0]          rnd, tsum;
    logic [TW-1:0]        t;
    logic [TW-2:0]        af;
    logic [AW-1:0]        a_next;
    logic [QW-1:0]        qd_next;
    logic [34:0]          hm;
    logic [16:0]          rh_full;
    logic [36:0]          xm;
    logic [32:0]          q0;
    ctl_t                 ctl9_next;

    always_comb
    begin
        ctl9_next     = ctl_reg[8];
        ctl9_next.neg = sum8_reg[SW-1];
    end

    always_comb
    begin
        case (ctl_reg[9].mode)
            MODE_DERIV1: rnd = RND_D1;
            MODE_DERIV2: rnd = RND_D2;
            default:     rnd = RND_VAL;
        endcase
        tsum = {1'b0, mag9_reg} + rnd;
        t    = tsum[SW:F];
        af   = t[TW-1:1];
        // large values saturate anyway, cap keeps the divide narrow
        a_next = (|af[TW-2:AW]) ? {AW{1'b1}} : af[AW-1:0];
        qd_next = (ctl_reg[9].mode == MODE_DERIV1) ? QW'(af) : t;
    end

    assign hm      = 35'(a10_reg[32:16]) * 35'(M17);
    assign rh_full = a10_reg[32:16] - 17'(hm[34:18] * 17'd3);
    assign xm      = 37'(x11_reg) * 37'(M18);
    assign q0      = {qh11_reg, 16'd0} + 33'(xm[36:19]);

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            prod7_reg[j] <= taps6_reg[j] * w6_reg[j];
        end
        ctl_reg[7] <= ctl_reg[6];

        sum8_reg <= SW'(prod7_reg[0]) + SW'(prod7_reg[1])
                  + SW'(prod7_reg[2]) + SW'(prod7_reg[3]);
        ctl_reg[8] <= ctl_reg[7];

        mag9_reg   <= sum8_reg[SW-1] ? SW'(-sum8_reg) : SW'(sum8_reg);
        ctl_reg[9] <= ctl9_next;

        a10_reg     <= a_next;
        qd10_reg    <= qd_next;
        ctl_reg[10] <= ctl_reg[9];

        qh11_reg    <= hm[34:18];
        x11_reg     <= {rh_full[1:0], a10_reg[15:0]};
        qd11_reg    <= qd10_reg;
        ctl_reg[11] <= ctl_reg[10];

        q12_reg     <= (ctl_reg[11].mode == MODE_DERIV1 || ctl_reg[11].mode == MODE_DERIV2)
                       ? qd11_reg : QW'(q0);
        ctl_reg[12] <= ctl_reg[11];
    end

    // ------------------------------------------------------------------------
    // stages 13 to 17: second derivative scaling by inv_dx twice, saturation
    // ------------------------------------------------------------------------
    logic [63:0]        p1lo13_reg, p2lo15_reg;
    logic [QW-1:0]      p1hi13_reg;
    logic [M1W-1:0]     p2hi15_reg;
    logic [QW-1:0]      q13_reg;
    logic [M1W-1:0]     m14_reg, m15_reg;
    logic [63:0]        m16_reg;
    result_t            res_reg;

    logic [QW+31:0]     big1;
    logic [QW+31-F:0]   r1;
    logic [M1W-1:0]     m1_next;
    logic [M1W+31:0]    big2;
    logic [63:0]        m2_next;
    logic               d2_14, d2_16;
    result_t            res_next;

    assign d2_14 = ctl_reg[13].mode == MODE_DERIV2;
    assign d2_16 = ctl_reg[15].mode == MODE_DERIV2;

    always_comb
    begin
        big1 = {p1hi13_reg, 32'd0} + (QW+32)'(p1lo13_reg) + RND_M1;
        r1   = big1[QW+31:F];
        if (d2_14)
        begin
            m1_next = (|r1[QW+31-F:M1W]) ? {M1W{1'b1}} : r1[M1W-1:0];
        end
        else
        begin
            m1_next = M1W'(q13_reg);
        end
        big2    = {p2hi15_reg, 32'd0} + (M1W+32)'(p2lo15_reg) + RND_M2;
        m2_next = d2_16 ? big2[F+63:F] : 64'(m15_reg);
    end

    always_comb
    begin
        res_next.out_of_range = ctl_reg[16].oor;
        res_next.saturated    = 1'b0;
        res_next.result_value = ctl_reg[16].neg ? -m16_reg[31:0] : m16_reg[31:0];
        if (!ctl_reg[16].neg && (m16_reg > 64'h0000_0000_7FFF_FFFF))
        begin
            res_next.result_value = 32'sh7FFF_FFFF;
            res_next.saturated    = 1'b1;
        end
        else if (ctl_reg[16].neg && (m16_reg > 64'h0000_0000_8000_0000))
        begin
            res_next.result_value = 32'sh8000_0000;
            res_next.saturated    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        p1lo13_reg  <= {32'd0, q12_reg[31:0]} * {32'd0, inv_dx_reg};
        p1hi13_reg  <= QW'(q12_reg[QW-1:32]) * QW'(inv_dx_reg);
        q13_reg     <= q12_reg;
        ctl_reg[13] <= ctl_reg[12];

        m14_reg     <= m1_next;
        ctl_reg[14] <= ctl_reg[13];

        p2lo15_reg  <= {32'd0, m14_reg[31:0]} * {32'd0, inv_dx_reg};
        p2hi15_reg  <= M1W'(m14_reg[M1W-1:32]) * M1W'(inv_dx_reg);
        m15_reg     <= m14_reg;
        ctl_reg[15] <= ctl_reg[14];

        m16_reg     <= m2_next;
        ctl_reg[16] <= ctl_reg[15];

        res_reg     <= res_next;
    end

    assign done   = vld_reg[LAT];
    assign result = res_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // every evaluate transfer is followed by a result
    a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.cmd == CMD_EVAL) |-> ##LAT done)
        else $error("evaluate item produced no result");

    // no result without an evaluate transfer at the matching edge
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (item.cmd == CMD_EVAL), LAT))
        else $error("result without matching evaluate item");

    // a clipped result sits at one of the range limits
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |->
            (result.result_value == 32'sh7FFF_FFFF) ||
            (result.result_value == 32'sh8000_0000))
        else $error("saturated flag with in-range value");

endmodule
